// ===== design/metp_pkg.sv =====
// Shared types and constants for the escape-time pixel core.
// Holds the configuration and result bundles, register indices and reset values.
// No dependencies; the top level and metp_engine refer to it by scoped names.
package metp_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Pixel positions wrap at this line length.
    localparam int MAX_LINE_PIXELS = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_ORIGIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_STEP    = 2'd3;

    localparam logic [15:0]        RST_MAX_ITER     = 16'd256;
    localparam logic [7:0]         RST_COLOUR_COUNT = 8'd255;
    localparam logic signed [31:0] RST_REAL_ORIGIN  = 32'shE000_0000;
    localparam logic signed [31:0] RST_REAL_STEP    = 32'sh0003_0000;

    typedef struct packed {
        logic [15:0]        max_iterations;
        logic [7:0]         colour_count;
        logic signed [31:0] real_origin;
        logic signed [31:0] real_step;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  colour_index;
        logic        escaped;
        logic [15:0] iterations_used;
        logic        last_in_line;
    } res_t;

endpackage

// ===== design/mandelbrot_escape_time_pixel_core.sv =====
// Top level of the escape-time pixel core: register file, request handshake
// and result register. Depends on metp_pkg and instantiates metp_engine.
//
// Each request describes one pixel: the imaginary coordinate of its line, its
// index along the line and a line-end mark. The real coordinate is formed as
// real_origin plus real_step times the index, and the point is iterated with
// z = z*z + c on a single shared 32 x 32 multiplier, which produces the real
// square, the imaginary square and the cross product of one iteration on
// successive cycles. Each iteration passes through the states ST_RR, ST_II,
// ST_RI and ST_UPD of metp_engine; the escape test |z|^2 >= 4 is made in ST_RI,
// before the update. A point that never escapes stops after max_iterations
// updates, or right after ST_CX when the limit is zero; the reset limit is
// 256. The result strobe done is registered from the engine's ST_FIN state.
// busy is high from acceptance until the cycle in which done is
// raised, and a new request is accepted at any edge where start is high and
// busy is low, including the edge that ends the done cycle. The result is
// shown for exactly one cycle and there is no way to hold it off, so the
// receiver must take it when done is high. Registers are written through
// cfg_we, cfg_index and cfg_data, and should only be changed while busy is low.
module mandelbrot_escape_time_pixel_core
#(
    parameter int FRAC_BITS = 28
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [31:0]                  imag_coord,
    input  logic [11:0]                         pixel_index,
    input  logic                                line_end,
    output logic                                done,
    output logic [7:0]                          colour_index,
    output logic                                escaped,
    output logic [15:0]                         iterations_used,
    output logic                                last_in_line,
    input  logic                                cfg_we,
    input  logic [metp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [metp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    metp_pkg::cfg_t cfg_reg, cfg_next;
    metp_pkg::res_t res_reg;
    metp_pkg::res_t eng_res;
    logic           busy_reg, busy_next;
    logic           done_reg;
    logic           go;
    logic           eng_fin;

    // A request is taken only while no pixel is in flight.
    assign go = start && !busy_reg;

    metp_engine
    #(
        .FRAC_BITS (FRAC_BITS)
    )
    u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .imag_coord  (imag_coord),
        .pixel_index (pixel_index),
        .line_end    (line_end),
        .cfg         (cfg_reg),
        .fin         (eng_fin),
        .res         (eng_res)
    );

    // Register writes; all four indices are defined, so nothing is dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                metp_pkg::CFG_MAX_ITER:     cfg_next.max_iterations = cfg_data[15:0];
                metp_pkg::CFG_COLOUR_COUNT: cfg_next.colour_count   = cfg_data[7:0];
                metp_pkg::CFG_REAL_ORIGIN:  cfg_next.real_origin    = $signed(cfg_data);
                metp_pkg::CFG_REAL_STEP:    cfg_next.real_step      = $signed(cfg_data);
                default:                    cfg_next                = cfg_reg;
            endcase
        end
    end

    // The busy flag rises on acceptance and falls as the result is registered.
    always_comb
    begin
        busy_next = busy_reg;
        if (go)
        begin
            busy_next = 1'b1;
        end
        else if (eng_fin)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_iterations <= metp_pkg::RST_MAX_ITER;
            cfg_reg.colour_count   <= metp_pkg::RST_COLOUR_COUNT;
            cfg_reg.real_origin    <= metp_pkg::RST_REAL_ORIGIN;
            cfg_reg.real_step      <= metp_pkg::RST_REAL_STEP;
            busy_reg               <= 1'b0;
            done_reg               <= 1'b0;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            busy_reg <= busy_next;
            done_reg <= eng_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_fin)
        begin
            res_reg <= eng_res;
        end
    end

    assign busy            = busy_reg;
    assign done            = done_reg;
    assign colour_index    = res_reg.colour_index;
    assign escaped         = res_reg.escaped;
    assign iterations_used = res_reg.iterations_used;
    assign last_in_line    = res_reg.last_in_line;

endmodule

// ===== design/metp_mul.sv =====
// Shared signed 32 x 32 multiplier with a registered product.
// Standalone; used by metp_engine for every product of the iteration.
module metp_mul
(
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] prod
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;

    assign prod_next = 64'(a) * 64'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== design/metp_engine.sv =====
// Sequencer and datapath for one pixel of the escape-time iteration.
// Depends on metp_pkg for the configuration and result bundles, and on metp_mul.
module metp_engine
#(
    parameter int FRAC_BITS = 28
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic signed [31:0] imag_coord,
    input  logic [11:0]        pixel_index,
    input  logic               line_end,
    input  metp_pkg::cfg_t     cfg,
    output logic               fin,
    output metp_pkg::res_t     res
);

    // Width of a square or cross term once the fraction bits are dropped.
    localparam int SQ_W  = 65 - FRAC_BITS;
    localparam int SAT_W = 66;
    localparam logic [SAT_W-1:0]        FOUR   = SAT_W'(4) << FRAC_BITS;
    localparam logic signed [SAT_W-1:0] S32MAX = 66'sd2147483647;
    localparam logic signed [SAT_W-1:0] S32MIN = -66'sd2147483648;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CX,
        ST_RR,
        ST_II,
        ST_RI,
        ST_UPD,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0]     cy_reg, cy_next;
    logic signed [31:0]     cx_reg, cx_next;
    logic signed [31:0]     r_reg, r_next;
    logic signed [31:0]     im_reg, im_next;
    logic signed [SQ_W-1:0] rr_reg, rr_next;
    logic signed [SQ_W-1:0] ii_reg, ii_next;
    logic [15:0]            n_reg, n_next;
    logic [7:0]             cc_reg, cc_next;
    logic                   esc_reg, esc_next;
    logic                   last_reg, last_next;

    logic signed [31:0]     mul_a;
    logic signed [31:0]     mul_b;
    logic signed [63:0]     prod;
    logic [11:0]            idx_eff;
    logic signed [SQ_W-1:0] sq;
    logic signed [SQ_W-1:0] ri2;
    logic signed [SQ_W:0]   mag;
    logic                   esc_hit;
    logic signed [31:0]     cx_sat;
    logic [16:0]            n_inc;
    logic [8:0]             cc_inc;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] res_v;
        if (v > S32MAX)
        begin
            res_v = 32'sh7FFF_FFFF;
        end
        else if (v < S32MIN)
        begin
            res_v = 32'sh8000_0000;
        end
        else
        begin
            res_v = v[31:0];
        end
        return res_v;
    endfunction

    metp_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign idx_eff = 12'(pixel_index % metp_pkg::MAX_LINE_PIXELS);

    // The multiplier is steered by the state: first the pixel offset, then the
    // two squares and the cross product of each iteration.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mul_a = cfg.real_step;
                mul_b = $signed({20'd0, idx_eff});
            end
            ST_II:
            begin
                mul_a = im_reg;
                mul_b = im_reg;
            end
            ST_RI:
            begin
                mul_a = r_reg;
                mul_b = im_reg;
            end
            default:
            begin
                mul_a = r_reg;
                mul_b = r_reg;
            end
        endcase
    end

    // Arithmetic right shifts floor toward minus infinity.
    assign sq      = SQ_W'(prod >>> FRAC_BITS);
    assign ri2     = SQ_W'(prod >>> (FRAC_BITS - 1));
    assign mag     = (SQ_W+1)'(rr_reg) + (SQ_W+1)'(sq);
    assign esc_hit = SAT_W'(mag) >= FOUR;
    assign cx_sat  = sat32(SAT_W'(prod) + SAT_W'(cfg.real_origin));
    assign n_inc   = {1'b0, n_reg} + 17'd1;
    assign cc_inc  = {1'b0, cc_reg} + 9'd1;

    always_comb
    begin
        state_next = state_reg;
        cy_next    = cy_reg;
        cx_next    = cx_reg;
        r_next     = r_reg;
        im_next    = im_reg;
        rr_next    = rr_reg;
        ii_next    = ii_reg;
        n_next     = n_reg;
        cc_next    = cc_reg;
        esc_next   = esc_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    cy_next    = imag_coord;
                    last_next  = line_end;
                    n_next     = 16'd0;
                    cc_next    = 8'd0;
                    esc_next   = 1'b0;
                    state_next = ST_CX;
                end
            end
            ST_CX:
            begin
                cx_next = cx_sat;
                r_next  = cx_sat;
                im_next = cy_reg;
                if (cfg.max_iterations == 16'd0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_RR;
                end
            end
            ST_RR:
            begin
                state_next = ST_II;
            end
            ST_II:
            begin
                rr_next    = sq;
                state_next = ST_RI;
            end
            ST_RI:
            begin
                ii_next = sq;
                if (esc_hit)
                begin
                    esc_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                r_next  = sat32(SAT_W'(rr_reg) - SAT_W'(ii_reg) + SAT_W'(cx_reg));
                im_next = sat32(SAT_W'(ri2) + SAT_W'(cy_reg));
                n_next  = n_inc[15:0];
                // The colour count runs alongside the iteration count, modulo
                // the number of colours.
                if (cc_inc == {1'b0, cfg.colour_count})
                begin
                    cc_next = 8'd0;
                end
                else
                begin
                    cc_next = cc_inc[7:0];
                end
                if (n_inc == {1'b0, cfg.max_iterations})
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_RR;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cy_reg   <= cy_next;
        cx_reg   <= cx_next;
        r_reg    <= r_next;
        im_reg   <= im_next;
        rr_reg   <= rr_next;
        ii_reg   <= ii_next;
        n_reg    <= n_next;
        cc_reg   <= cc_next;
        esc_reg  <= esc_next;
        last_reg <= last_next;
    end

    assign fin = (state_reg == ST_FIN);

    always_comb
    begin
        if (cfg.colour_count == 8'd0)
        begin
            res.colour_index = 8'd0;
        end
        else if (esc_reg)
        begin
            res.colour_index = cc_reg;
        end
        else
        begin
            res.colour_index = cfg.colour_count;
        end
        res.escaped         = esc_reg;
        res.iterations_used = n_reg;
        res.last_in_line    = last_reg;
    end

endmodule

// ===== design/metp_checker.sv =====
// Port-level checks on the request and result timing of the pixel core.
// Bound to mandelbrot_escape_time_pixel_core; needs no package.
module metp_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // An accepted request always makes the core busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy did not rise");

    // A result is only produced for a request that was in flight.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in flight");

    // The core is free again in the cycle its result is shown.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy still high while a result is shown");

    // busy never drops without a result being delivered.
    a_busy_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

endmodule

bind mandelbrot_escape_time_pixel_core metp_checker u_metp_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
